### rtl/core/assert_macros.svh
// Assertion macros shared by the token scanner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Hold a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/ctsc_pkg.sv
// Types, constants and character classes for the C source token scanner.
package ctsc_pkg;

   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_USCORE = 8'h5F;

   localparam logic [7:0] MAX_LEN_RESET = 8'd99;
   localparam logic [7:0] MIN_LEN       = 8'd2;

   localparam int RSP_DEPTH_DEFAULT = 4;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_WORD    = 3'd1,
      MODE_PRE     = 3'd2,
      MODE_STR     = 3'd3,
      MODE_STR_ESC = 3'd4,
      MODE_COMMENT = 3'd5,
      MODE_SLASH   = 3'd6,
      MODE_SKIP    = 3'd7
   } mode_type;

   typedef enum logic [1:0] {
      KIND_WORD    = 2'd0,
      KIND_STRING  = 2'd1,
      KIND_COMMENT = 2'd2,
      KIND_PRE     = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  chr;
      logic        chr_valid;
      logic        tok_end;
      logic        unterm;
   } rsp_beat_type;

   // Results of one input beat, handed from the scanner to the result queue.
   typedef struct packed {
      logic [1:0]   count;
      rsp_beat_type beat0;
      rsp_beat_type beat1;
   } push_type;

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   function automatic logic is_word_char(input logic [7:0] c);
      return is_letter(c) || ((c >= 8'h30) && (c <= 8'h39)) || (c == CH_USCORE);
   endfunction

   function automatic logic in_token(input mode_type m);
      return (m >= MODE_WORD) && (m <= MODE_COMMENT);
   endfunction

   function automatic kind_type mode_kind(input mode_type m);
      kind_type k;
      case (m)
         MODE_PRE:                   k = KIND_PRE;
         MODE_STR, MODE_STR_ESC:     k = KIND_STRING;
         MODE_COMMENT:               k = KIND_COMMENT;
         default:                    k = KIND_WORD;
      endcase
      return k;
   endfunction

endpackage

### rtl/core/c_source_token_scanner_top.sv
// Top level of the C source token scanner: scanner step plus result queue.
//
//   channel  dir  payload
//   req_     in   tdata = ch[7:0], tuser = end_of_text
//   rsp_     out  tdata = char_out, tuser = kind/char_valid/unterminated, tlast = token_end
//   csr_     in   csr_wdata = max_token_len, written when csr_we is high
//
// One character beat is accepted per clock while the queue has room; the scanner state
// updates in the same cycle and its results (zero, one or two beats) land in the queue.
// With both sides ready, a character giving one result sustains one beat per clock; a
// two-result character (token close plus rescan, slash-star, closing quote or star-slash)
// adds an extra beat that the queue of RSP_DEPTH entries absorbs.
// req_tready drops only when the queue has fewer than two free entries; rsp_tready
// stalls do not disturb the scanner state. Reset is synchronous and clears the
// scanner state, the queue pointers and restores max_token_len to 99.
module c_source_token_scanner_top #(
   parameter int RSP_DEPTH = ctsc_pkg::RSP_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] ch
   input  logic [0:0] req_tuser,   // [0] end_of_text
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] char_out
   output logic [3:0] rsp_tuser,   // [1:0] token_kind, [2] char_valid, [3] unterminated
   output logic       rsp_tlast,   // token_end
   input  logic       csr_we,
   input  logic [7:0] csr_wdata    // max_token_len
);
   import ctsc_pkg::*;

   push_type     push;
   rsp_beat_type head;
   logic         accept;

   // Take a beat only while the queue can hold both possible results.
   assign accept = req_tvalid && req_tready;

   ctsc_step u_step (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .ch          (req_tdata),
      .end_of_text (req_tuser[0]),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .push        (push)
   );

   ctsc_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .has_room  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_beat  (head)
   );

   // Unpack the head of the queue onto the result beat.
   assign rsp_tdata = head.chr;
   assign rsp_tuser = {head.unterm, head.chr_valid, head.kind};
   assign rsp_tlast = head.tok_end;

endmodule

### rtl/core/ctsc_step.sv
// Scanner state, length register and the single-pass step logic.
`include "assert_macros.svh"

module ctsc_step (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        ch,
   input  logic              end_of_text,
   input  logic              csr_we,
   input  logic [7:0]        csr_wdata,
   output ctsc_pkg::push_type push
);
   import ctsc_pkg::*;

   typedef struct packed {
      mode_type     mode;
      logic [7:0]   len;
      logic         star;
      logic [1:0]   count;
      rsp_beat_type beat0;
      rsp_beat_type beat1;
   } step_type;

   mode_type   mode_ff, mode_in;
   logic [7:0] len_ff, len_in;
   logic       star_ff, star_in;
   logic [7:0] max_len_ff, max_len_in;
   logic [7:0] limit;
   step_type   step_w;

   function automatic rsp_beat_type mk_char(input kind_type k, input logic [7:0] c);
      rsp_beat_type b;
      b.kind = k; b.chr = c; b.chr_valid = 1'b1; b.tok_end = 1'b0; b.unterm = 1'b0;
      return b;
   endfunction

   function automatic rsp_beat_type mk_end(input kind_type k, input logic u);
      rsp_beat_type b;
      b.kind = k; b.chr = 8'h00; b.chr_valid = 1'b0; b.tok_end = 1'b1; b.unterm = u;
      return b;
   endfunction

   function automatic step_type scan_step(input mode_type m, input logic [7:0] l,
                                          input logic s, input logic [7:0] lim,
                                          input logic [7:0] c, input logic eot);
      step_type     r;
      rsp_beat_type res [2];
      logic [1:0]   n;
      logic         rescan;
      r.mode = m; r.len = l; r.star = s;
      n = 2'd0;
      rescan = 1'b0;
      res[0] = '0;
      res[1] = '0;
      // Cut a token that has reached the limit.
      if (in_token(r.mode) && (r.len >= lim)) begin
         res[n[0]] = mk_end(mode_kind(r.mode), 1'b0);
         n = n + 2'd1;
         r.mode = MODE_IDLE; r.len = 8'd0; r.star = 1'b0;
      end
      if (eot) begin
         if (in_token(r.mode)) begin
            res[n[0]] = mk_end(mode_kind(r.mode),
                               !((r.mode == MODE_WORD) || (r.mode == MODE_PRE)));
            n = n + 2'd1;
         end
         r.mode = MODE_IDLE; r.len = 8'd0; r.star = 1'b0;
      end else begin
         case (r.mode)
            MODE_WORD, MODE_PRE: begin
               if (is_word_char(c)) begin
                  res[n[0]] = mk_char(mode_kind(r.mode), c);
                  n = n + 2'd1; r.len = r.len + 8'd1;
               end else begin
                  res[n[0]] = mk_end(mode_kind(r.mode), 1'b0);
                  n = n + 2'd1;
                  r.mode = MODE_IDLE; r.len = 8'd0; r.star = 1'b0;
                  rescan = 1'b1;
               end
            end
            MODE_STR: begin
               res[n[0]] = mk_char(KIND_STRING, c);
               n = n + 2'd1; r.len = r.len + 8'd1;
               if (c == CH_QUOTE) begin
                  res[n[0]] = mk_end(KIND_STRING, 1'b0);
                  n = n + 2'd1;
                  r.mode = MODE_IDLE; r.len = 8'd0; r.star = 1'b0;
               end else if (c == CH_BSLASH) begin
                  r.mode = MODE_STR_ESC;
               end
            end
            MODE_STR_ESC: begin
               res[n[0]] = mk_char(KIND_STRING, c);
               n = n + 2'd1; r.len = r.len + 8'd1;
               r.mode = MODE_STR;
            end
            MODE_COMMENT: begin
               res[n[0]] = mk_char(KIND_COMMENT, c);
               n = n + 2'd1; r.len = r.len + 8'd1;
               if ((c == CH_SLASH) && r.star) begin
                  res[n[0]] = mk_end(KIND_COMMENT, 1'b0);
                  n = n + 2'd1;
                  r.mode = MODE_IDLE; r.len = 8'd0; r.star = 1'b0;
               end else begin
                  r.star = (c == CH_STAR);
               end
            end
            MODE_SLASH: begin
               if (c == CH_STAR) begin
                  r.mode = MODE_COMMENT; r.star = 1'b0;
                  res[0] = mk_char(KIND_COMMENT, CH_SLASH);
                  res[1] = mk_char(KIND_COMMENT, CH_STAR);
                  n = 2'd2; r.len = 8'd2;
               end else begin
                  rescan = 1'b1;
               end
            end
            MODE_SKIP: begin
               r.mode = MODE_IDLE;
            end
            default: begin
               rescan = 1'b1;
            end
         endcase
         // Scan the character anew from idle.
         if (rescan) begin
            r.len = 8'd0; r.star = 1'b0;
            if (is_letter(c) || (c == CH_USCORE)) begin
               r.mode = MODE_WORD;
               res[n[0]] = mk_char(KIND_WORD, c);
               n = n + 2'd1; r.len = 8'd1;
            end else if (c == CH_HASH) begin
               r.mode = MODE_PRE;
               res[n[0]] = mk_char(KIND_PRE, c);
               n = n + 2'd1; r.len = 8'd1;
            end else if (c == CH_QUOTE) begin
               r.mode = MODE_STR;
               res[n[0]] = mk_char(KIND_STRING, c);
               n = n + 2'd1; r.len = 8'd1;
            end else if (c == CH_SLASH) begin
               r.mode = MODE_SLASH;
            end else if (c == CH_BSLASH) begin
               r.mode = MODE_SKIP;
            end else begin
               r.mode = MODE_IDLE;
            end
         end
      end
      r.count = n;
      r.beat0 = res[0];
      r.beat1 = res[1];
      return r;
   endfunction

   assign limit  = (max_len_ff < MIN_LEN) ? MIN_LEN : max_len_ff;
   assign step_w = scan_step(mode_ff, len_ff, star_ff, limit, ch, end_of_text);

   // Next state: the scanner advances only on an accepted beat; max_len takes csr_wdata on csr_we.
   always_comb begin
      mode_in    = mode_ff;
      len_in     = len_ff;
      star_in    = star_ff;
      max_len_in = csr_we ? csr_wdata : max_len_ff;
      if (accept) begin
         mode_in = step_w.mode;
         len_in  = step_w.len;
         star_in = step_w.star;
      end
   end

   // Outputs: results of the accepted beat.
   always_comb begin
      push.count = accept ? step_w.count : 2'd0;
      push.beat0 = step_w.beat0;
      push.beat1 = step_w.beat1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_IDLE;
         len_ff     <= 8'd0;
         star_ff    <= 1'b0;
         max_len_ff <= MAX_LEN_RESET;
      end else begin
         mode_ff    <= mode_in;
         len_ff     <= len_in;
         star_ff    <= star_in;
         max_len_ff <= max_len_in;
      end
   end

   `ASSERT_IMPLIES(a_len_idle, clock, reset, !in_token(mode_ff), len_ff == 8'd0, "length outside token")
   `ASSERT_IMPLIES(a_star_comment, clock, reset, star_ff, mode_ff == MODE_COMMENT, "star flag outside comment")
   `ASSERT_ALWAYS(a_push_count, clock, reset, push.count != 2'd3, "more than two results")

endmodule

### rtl/core/ctsc_fifo.sv
// Result queue: takes up to two beats per cycle, delivers one while out_ready is high.
`include "assert_macros.svh"

module ctsc_fifo #(
   parameter int DEPTH = ctsc_pkg::RSP_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ctsc_pkg::push_type     push,
   output logic                   has_room,
   output logic                   out_valid,
   input  logic                   out_ready,
   output ctsc_pkg::rsp_beat_type out_beat
);
   import ctsc_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
   localparam logic [CW-1:0] ROOM = CW'(DEPTH - 2);

   rsp_beat_type  mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, wr_ptr_nx;
   logic [CW-1:0] count_ff, count_in;
   logic          pop;

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
      return (p == LAST) ? '0 : p + 1'b1;
   endfunction

   assign has_room  = (count_ff <= ROOM);
   assign out_valid = (count_ff != '0);
   assign out_beat  = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   assign wr_ptr_nx = wrap_inc(wr_ptr_ff);

   always_comb begin
      rd_ptr_in = pop ? wrap_inc(rd_ptr_ff) : rd_ptr_ff;
      case (push.count)
         2'd1:    wr_ptr_in = wr_ptr_nx;
         2'd2:    wr_ptr_in = wrap_inc(wr_ptr_nx);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      count_in = count_ff + CW'(push.count) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.beat0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_nx] <= push.beat1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `ASSERT_ALWAYS(a_no_overflow, clock, reset, count_ff <= CW'(DEPTH), "queue overflow")
   `ASSERT_IMPLIES(a_push_fits, clock, reset, push.count != 2'd0, CW'(push.count) <= CW'(DEPTH) - count_ff, "push without room")
   `ASSERT_NEXT(a_pop_only, clock, reset, pop && (push.count == 2'd0), count_ff == $past(count_ff) - 1'b1, "pop miscounted")

endmodule

### tb/c_source_token_scanner_top_tb.sv
// Self-checking stream bench for the C source token scanner: predicts every token beat.
module c_source_token_scanner_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ctsc_pkg::*;

   // Let the result queue settle after the last expected beat before touching the register.
   localparam int SETTLE_CYCLES = 8;
   // Cycles with no beat moving on either side before the run is declared hung.
   localparam int STALL_LIMIT   = 4000;
   // Characters per random phase; five phases plus the directed text give about 400.
   localparam int PHASE_ITEMS   = 75;
   // Largest limit at which random pieces are stretched across it.
   localparam int STRADDLE_MAX  = 16;

   // One character beat towards the scanner.
   typedef struct packed {
      logic       eot;
      logic [7:0] ch;
   } char_beat_type;

   // Tracks the scanner state, predicts the token beats of each accepted character
   // and checks the beats that come out against them in order.
   class token_scan_checker;
      mode_type     mode;
      logic [7:0]   tok_len;
      logic         prev_star;
      logic [7:0]   max_len;
      int           errors;
      rsp_beat_type due_beats[$];

      function new();
         mode      = MODE_IDLE;
         tok_len   = 8'd0;
         prev_star = 1'b0;
         max_len   = MAX_LEN_RESET;
         errors    = 0;
      endfunction

      function void set_max_len(logic [7:0] v);
         max_len = v;
      endfunction

      function int outstanding();
         return due_beats.size();
      endfunction

      function logic alpha(logic [7:0] c);
         return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
      endfunction

      function logic word_char(logic [7:0] c);
         return alpha(c) || (c >= "0" && c <= "9") || c == CH_USCORE;
      endfunction

      function logic open_token();
         return mode inside {MODE_WORD, MODE_PRE, MODE_STR, MODE_STR_ESC, MODE_COMMENT};
      endfunction

      function kind_type kind_now();
         case (mode)
            MODE_PRE:               return KIND_PRE;
            MODE_STR, MODE_STR_ESC: return KIND_STRING;
            MODE_COMMENT:           return KIND_COMMENT;
            default:                return KIND_WORD;
         endcase
      endfunction

      function void put_char(logic [7:0] c);
         due_beats.push_back('{kind: kind_now(), chr: c, chr_valid: 1'b1,
                               tok_end: 1'b0, unterm: 1'b0});
         tok_len = tok_len + 8'd1;
      endfunction

      function void put_end(logic unterm);
         due_beats.push_back('{kind: kind_now(), chr: 8'h00, chr_valid: 1'b0,
                               tok_end: 1'b1, unterm: unterm});
         mode      = MODE_IDLE;
         tok_len   = 8'd0;
         prev_star = 1'b0;
      endfunction

      // Start on a character with no token open.
      function void scan_fresh(logic [7:0] c);
         tok_len   = 8'd0;
         prev_star = 1'b0;
         if (alpha(c) || c == CH_USCORE) begin
            mode = MODE_WORD;
            put_char(c);
         end else if (c == CH_HASH) begin
            mode = MODE_PRE;
            put_char(c);
         end else if (c == CH_QUOTE) begin
            mode = MODE_STR;
            put_char(c);
         end else if (c == CH_SLASH) begin
            mode = MODE_SLASH;
         end else if (c == CH_BSLASH) begin
            mode = MODE_SKIP;
         end else begin
            mode = MODE_IDLE;
         end
      endfunction

      function void take_char(logic [7:0] c, logic eot);
         logic [7:0] lim;
         lim = (max_len < MIN_LEN) ? MIN_LEN : max_len;
         // A full token is cut first; the character is then scanned from idle.
         if (open_token() && tok_len >= lim)
            put_end(1'b0);
         if (eot) begin
            if (open_token())
               put_end((mode inside {MODE_WORD, MODE_PRE}) ? 1'b0 : 1'b1);
            mode      = MODE_IDLE;
            tok_len   = 8'd0;
            prev_star = 1'b0;
            return;
         end
         case (mode)
            MODE_WORD, MODE_PRE: begin
               if (word_char(c)) begin
                  put_char(c);
               end else begin
                  put_end(1'b0);
                  scan_fresh(c);
               end
            end
            MODE_STR: begin
               put_char(c);
               if (c == CH_QUOTE)
                  put_end(1'b0);
               else if (c == CH_BSLASH)
                  mode = MODE_STR_ESC;
            end
            MODE_STR_ESC: begin
               put_char(c);
               mode = MODE_STR;
            end
            MODE_COMMENT: begin
               put_char(c);
               if (c == CH_SLASH && prev_star)
                  put_end(1'b0);
               else
                  prev_star = (c == CH_STAR);
            end
            MODE_SLASH: begin
               if (c == CH_STAR) begin
                  mode      = MODE_COMMENT;
                  tok_len   = 8'd0;
                  prev_star = 1'b0;
                  put_char(CH_SLASH);
                  put_char(CH_STAR);
               end else begin
                  scan_fresh(c);
               end
            end
            MODE_SKIP: mode = MODE_IDLE;
            default:   scan_fresh(c);
         endcase
      endfunction

      function void note_mismatch(string field, logic [7:0] want_v, logic [7:0] got_v);
         if (want_v !== got_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want_v, got_v);
            errors++;
         end
      endfunction

      function void check_beat(rsp_beat_type got);
         rsp_beat_type want;
         if (due_beats.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual kind %0d chr %0h valid %0b end %0b unterm %0b",
                     $time, got.kind, got.chr, got.chr_valid, got.tok_end, got.unterm);
            errors++;
            return;
         end
         want = due_beats.pop_front();
         note_mismatch("token_kind", 8'(want.kind), 8'(got.kind));
         note_mismatch("char_out", want.chr, got.chr);
         note_mismatch("char_valid", 8'(want.chr_valid), 8'(got.chr_valid));
         note_mismatch("token_end", 8'(want.tok_end), 8'(got.tok_end));
         note_mismatch("unterminated", 8'(want.unterm), 8'(got.unterm));
      endfunction
   endclass

   logic       clock;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;
   logic [0:0] req_tuser  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [3:0] rsp_tuser;
   logic       rsp_tlast;
   logic       csr_we     = 1'b0;
   logic [7:0] csr_wdata  = 8'h00;

   token_scan_checker sb;
   char_beat_type     stim_q[$];
   int                send_idle_pct = 31;
   int                recv_idle_pct = 59;
   int                stall_cycles  = 0;

   c_source_token_scanner_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Receiver: stall at random at the current rate; a zero rate keeps it always ready.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Monitor: sample both handshakes at the edge, before any driver update lands.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.take_char(req_tdata, req_tuser[0]);
         if (rsp_tvalid && rsp_tready)
            sb.check_beat('{kind: kind_type'(rsp_tuser[1:0]), chr: rsp_tdata,
                            chr_valid: rsp_tuser[2], tok_end: rsp_tlast,
                            unterm: rsp_tuser[3]});
      end
   end

   // Watchdog: give up when no beat has moved on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("[c_source_token_scanner_top] ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic void add_char(logic [7:0] c);
      stim_q.push_back('{eot: 1'b0, ch: c});
   endfunction

   // End of text; the character lane carries junk that must be ignored.
   function automatic void add_end();
      stim_q.push_back('{eot: 1'b1, ch: 8'($urandom_range(0, 255))});
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++)
         add_char(s[i]);
   endfunction

   function automatic logic [7:0] rand_word_char();
      case ($urandom_range(0, 3))
         0:       return 8'($urandom_range("a", "z"));
         1:       return 8'($urandom_range("A", "Z"));
         2:       return 8'($urandom_range("0", "9"));
         default: return CH_USCORE;
      endcase
   endfunction

   function automatic logic [7:0] rand_word_start();
      case ($urandom_range(0, 3))
         0:       return CH_USCORE;
         1:       return 8'($urandom_range("A", "Z"));
         default: return 8'($urandom_range("a", "z"));
      endcase
   endfunction

   // Body of a string or comment: mostly printable, now and then any byte at all.
   function automatic logic [7:0] rand_body_char();
      if ($urandom_range(0, 7) == 0)
         return 8'($urandom_range(0, 255));
      return 8'($urandom_range(8'h20, 8'h7E));
   endfunction

   // Append one piece of C-like text. Lengths are mostly short; at small limits one
   // piece in ten straddles the limit so that cuts happen often without long runs.
   function automatic void add_fragment();
      string seps = " \t\n;(),=+-0123456789{}[]<>";
      int    lim;
      int    len;
      lim = (sb.max_len < MIN_LEN) ? MIN_LEN : sb.max_len;
      len = ((lim <= STRADDLE_MAX) && ($urandom_range(0, 9) == 0))
               ? $urandom_range(lim - 1, lim + 2)
               : $urandom_range(1, 6);
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4: begin
            add_char(rand_word_start());
            repeat (len - 1) add_char(rand_word_char());
         end
         5, 6: begin
            add_char(CH_HASH);
            repeat (len - 1) add_char(rand_word_char());
         end
         7, 8, 9: begin
            add_char(CH_QUOTE);
            repeat (len) begin
               if ($urandom_range(0, 5) == 0)
                  add_char(CH_BSLASH);
               add_char(rand_body_char());
            end
            if ($urandom_range(0, 7) != 0)
               add_char(CH_QUOTE);
         end
         10, 11, 12: begin
            add_char(CH_SLASH);
            add_char(CH_STAR);
            repeat (len) add_char(($urandom_range(0, 3) == 0) ? CH_STAR : rand_body_char());
            if ($urandom_range(0, 7) != 0) begin
               add_char(CH_STAR);
               add_char(CH_SLASH);
            end
         end
         13: begin
            add_char(CH_SLASH);
            add_char(rand_body_char());
         end
         14: begin
            add_char(CH_BSLASH);
            add_char(8'($urandom_range(0, 255)));
         end
         15: repeat ($urandom_range(1, 4)) add_char(8'($urandom_range(0, 255)));
         16, 17: repeat ($urandom_range(1, 3)) add_char(seps[$urandom_range(0, seps.len() - 1)]);
         18: add_end();
         default: begin
            // Closing pair, usually outside any comment.
            add_char(CH_STAR);
            add_char(CH_SLASH);
         end
      endcase
   endfunction

   // Present one beat, with random gaps ahead of it, and hold it until accepted.
   // tvalid is left high afterwards so the next beat can follow without a bubble.
   task automatic send_beat(input char_beat_type b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b.ch;
      req_tuser  <= b.eot;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drive_all();
      while (stim_q.size() != 0)
         send_beat(stim_q.pop_front());
      req_tvalid <= 1'b0;
   endtask

   task automatic run_random(input int n_items);
      while (stim_q.size() < n_items)
         add_fragment();
      drive_all();
   endtask

   // Wait for every predicted beat to come out, then let the block go quiet.
   task automatic wait_drained();
      @(posedge clock);
      while (sb.outstanding() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the length limit only once the pipeline has drained.
   task automatic write_max_len(input logic [7:0] v);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      sb.set_max_len(v);
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed text at the reset limit: word ended by '#', preprocessor word,
      // string with an escaped quote, comment whose opening star must not close it,
      // lone slash, stray backslash, string left open at end of text, slash pending
      // at end of text, and a word left open across the register write.
      add_text("_Z9#if\"\\\"\"/*/*//x\\a\"q");
      add_end();
      add_char(CH_SLASH);
      add_end();
      add_text("zz");
      drive_all();

      // Limit below the minimum acts as two: the open word is cut on the first beat,
      // then a comment opener is cut straight away; extreme byte values go through.
      write_max_len(8'd0);
      add_text("a/*");
      add_char(8'h00);
      add_char(8'hFF);
      add_end();
      drive_all();

      write_max_len(8'd255);
      run_random(PHASE_ITEMS);

      // Swap the idling of the two sides.
      send_idle_pct = 59;
      recv_idle_pct = 31;
      write_max_len(MIN_LEN);
      run_random(PHASE_ITEMS);
      write_max_len(8'd1);
      run_random(PHASE_ITEMS);

      // Full rate on both sides.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_max_len(8'($urandom_range(3, 254)));
      run_random(PHASE_ITEMS);
      write_max_len(8'd6);
      run_random(PHASE_ITEMS);

      wait_drained();
      if (sb.errors == 0 && sb.outstanding() == 0)
         $display("[c_source_token_scanner_top] OK");
      else
         $display("[c_source_token_scanner_top] ERROR");
      $finish;
   end

endmodule

### c_source_token_scanner_top.f
+incdir+rtl/core
rtl/core/ctsc_pkg.sv
rtl/core/ctsc_step.sv
rtl/core/ctsc_fifo.sv
rtl/core/c_source_token_scanner_top.sv
tb/c_source_token_scanner_top_tb.sv
